// ===== rtl/separable_box_blur_gray_macros.svh =====
`ifndef SEPARABLE_BOX_BLUR_GRAY_MACROS_SVH
`define SEPARABLE_BOX_BLUR_GRAY_MACROS_SVH

// Same-cycle implication on clk, off during reset.
`define SBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, off during reset.
`define SBB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbb_pkg.sv =====
package sbb_pkg;

  localparam int MAX_WIDTH     = 512;
  localparam int MAX_HEIGHT    = 512;
  localparam int MAX_RADIUS    = 63;
  localparam int STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int SCRATCH_DEPTH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SCR_AW        = $clog2(SCRATCH_DEPTH);

  localparam int DIM_W     = 10;
  localparam int TOT_W     = 2 * DIM_W;
  localparam int RAD_W     = 6;
  localparam int PIX_W     = 8;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;
  localparam int PIX_MAX   = 2 ** PIX_W - 1;
  localparam int WIN_W     = $clog2(2 * MAX_RADIUS + 2);
  localparam int SUM_W     = $clog2((2 * MAX_RADIUS + 1) * PIX_MAX + 1);
  localparam int QSTEP_W   = $clog2(PIX_W);

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd480;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd360;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 6'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_RESULT,
    S_LINE_START,
    S_PRIME_RD,
    S_PRIME_ACC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SLIDE_OLD,
    S_SLIDE_SUB,
    S_SLIDE_ADD,
    S_COPY_RD,
    S_COPY_WR,
    S_LINE_NEXT
  } blur_state_t;

endpackage

// ===== rtl/sbb_div.sv =====
`include "separable_box_blur_gray_macros.svh"

// Restoring divider: one quotient bit per cycle, quotient known to fit PIX_W bits.
module sbb_div import sbb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [WIN_W-1:0] divisor,
  output logic             done,
  output logic [PIX_W-1:0] quotient
);

  logic               busy;
  logic [QSTEP_W-1:0] step;
  logic [SUM_W-1:0]   rem;
  logic [SUM_W-1:0]   dshift;
  logic               fits;

  assign dshift = SUM_W'(divisor) << step;
  assign fits   = rem >= dshift;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == '0);
      if (start) begin
        busy <= 1'b1;
        step <= QSTEP_W'(PIX_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      quotient <= '0;
    end else if (busy && fits) begin
      rem            <= rem - dshift;
      quotient[step] <= 1'b1;
    end
  end

  `SBB_ASSERT_IMP(a_start_idle, start, !busy, "divider started while busy")
  `SBB_ASSERT_NXT(a_last_done, busy && (step == '0) && !start, done, "divider missed done")
  `SBB_ASSERT_IMP(a_done_idle, done, !busy, "done raised while still busy")

endmodule

// ===== rtl/separable_box_blur_gray.sv =====
// Grayscale frame store with in-place separable box blur. Opcode 0 writes the
// next pixel in raster order, opcode 2 returns the next pixel, both through one
// wrapping raster pointer; opcode 1 blurs rows, then columns, with a window of
// 2*radius+1 and a running sum, answering 1 when done or 2 when the window is
// wider or taller than the frame (frame left alone). Every run resets the
// pointer. A run walks each line through the single-port frame memory and one
// shared restoring divider, over all rows and then all columns. Item acceptance
// stops for the whole run. A finished result waits in the output register while
// further loads are taken. Loads are taken back to back; a read holds off
// further items until its result is registered.
`include "separable_box_blur_gray_macros.svh"

module separable_box_blur_gray import sbb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      opcode,
  input  logic [PIX_W-1:0]     pixel_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    result_kind,
  output logic [PIX_W-1:0]     pixel_out,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  blur_state_t state, state_next;

  logic [DIM_W-1:0]  reg_width;
  logic [DIM_W-1:0]  reg_height;
  logic [RAD_W-1:0]  reg_radius;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [RAD_W-1:0]  r_eff;
  logic [WIN_W-1:0]  win;
  logic [TOT_W-1:0]  total;
  logic              refuse;

  logic [ADDR_W-1:0] ptr;
  logic [TOT_W-1:0]  ptr_eff;
  logic [TOT_W-1:0]  ptr_inc;
  logic [ADDR_W-1:0] ptr_next;

  logic              pass_vert;
  logic [DIM_W-1:0]  li;
  logic [DIM_W-1:0]  k;
  logic [WIN_W-1:0]  cnt;
  logic [SUM_W-1:0]  sum;
  logic [ADDR_W-1:0] line_base;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] tail;
  logic [ADDR_W-1:0] wb;
  logic [DIM_W-1:0]  n_len;
  logic [DIM_W-1:0]  n_lines;
  logic [ADDR_W-1:0] stride;
  logic [ADDR_W-1:0] line_step;
  logic              more;
  logic              more_lines;

  logic [KIND_W-1:0] res_kind;
  logic [PIX_W-1:0]  res_pix;
  logic              in_fire;
  logic              out_free;

  logic [PIX_W-1:0]  frame_mem [STORE_DEPTH];
  logic [ADDR_W-1:0] frame_addr;
  logic              frame_we;
  logic [PIX_W-1:0]  frame_wdata;
  logic [PIX_W-1:0]  frame_q;

  logic [PIX_W-1:0]  scr_mem [SCRATCH_DEPTH];
  logic              scr_we;
  logic [PIX_W-1:0]  scr_q;

  logic              div_start;
  logic              div_done;
  logic [PIX_W-1:0]  div_quot;

  // Effective geometry
  always_comb begin
    if (reg_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (reg_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = reg_width;
    end
    if (reg_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (reg_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = reg_height;
    end
    if (reg_radius > RAD_W'(MAX_RADIUS)) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = reg_radius;
    end
  end

  assign win    = {r_eff, 1'b1};
  assign total  = TOT_W'(w_eff) * TOT_W'(h_eff);
  assign refuse = (DIM_W'(win) > w_eff) || (DIM_W'(win) > h_eff);

  // Raster pointer wrap: a stale pointer past the frame counts as zero
  assign ptr_eff  = (TOT_W'(ptr) >= total) ? '0 : TOT_W'(ptr);
  assign ptr_inc  = ptr_eff + 1'b1;
  assign ptr_next = (ptr_inc >= total) ? '0 : ADDR_W'(ptr_inc);

  assign n_len      = pass_vert ? h_eff : w_eff;
  assign n_lines    = pass_vert ? w_eff : h_eff;
  assign stride     = pass_vert ? ADDR_W'(w_eff) : ADDR_W'(1);
  assign line_step  = pass_vert ? ADDR_W'(1) : ADDR_W'(w_eff);
  assign more       = ((DIM_W+1)'(k) + (DIM_W+1)'(r_eff) + 1'b1) < (DIM_W+1)'(n_len);
  assign more_lines = ((DIM_W+1)'(li) + 1'b1) < (DIM_W+1)'(n_lines);

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_width  <= WIDTH_RESET;
      reg_height <= HEIGHT_RESET;
      reg_radius <= RADIUS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:  reg_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: reg_height <= cfg_data[DIM_W-1:0];
        REG_RADIUS: reg_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (opcode)
            OP_READ: state_next = S_RD_WAIT;
            OP_RUN:  state_next = refuse ? S_RESULT : S_LINE_START;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT:    state_next = S_RESULT;
      S_RESULT:     state_next = out_free ? S_IDLE : S_RESULT;
      S_LINE_START: state_next = S_PRIME_RD;
      S_PRIME_RD:   state_next = S_PRIME_ACC;
      S_PRIME_ACC:  state_next = (cnt == win) ? S_DIV_GO : S_PRIME_RD;
      S_DIV_GO:     state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = more ? S_SLIDE_OLD : S_COPY_RD;
        end
      end
      S_SLIDE_OLD:  state_next = S_SLIDE_SUB;
      S_SLIDE_SUB:  state_next = S_SLIDE_ADD;
      S_SLIDE_ADD:  state_next = S_DIV_GO;
      S_COPY_RD:    state_next = S_COPY_WR;
      S_COPY_WR:    state_next = more ? S_COPY_RD : S_LINE_NEXT;
      S_LINE_NEXT:  state_next = (more_lines || !pass_vert) ? S_LINE_START : S_RESULT;
      default:      state_next = S_IDLE;
    endcase
  end

  // Memory and divider controls
  always_comb begin
    frame_addr  = ADDR_W'(ptr_eff);
    frame_we    = 1'b0;
    frame_wdata = pixel_in;
    scr_we      = 1'b0;
    div_start   = 1'b0;
    unique case (state)
      S_IDLE:      frame_we = in_fire && (opcode == OP_LOAD);
      S_PRIME_RD:  frame_addr = head;
      S_SLIDE_OLD: frame_addr = tail;
      S_SLIDE_SUB: frame_addr = head;
      S_DIV_GO:    div_start = 1'b1;
      S_DIV_WAIT:  scr_we = div_done;
      S_COPY_WR: begin
        frame_addr  = wb;
        frame_we    = 1'b1;
        frame_wdata = scr_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        if (opcode == OP_LOAD || opcode == OP_READ) begin
          ptr <= ptr_next;
        end else if (opcode == OP_RUN) begin
          ptr <= '0;
        end
      end
    end
  end

  // Blur datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          res_pix   <= '0;
          res_kind  <= (opcode == OP_RUN) ? (refuse ? KIND_REFUSED : KIND_DONE) : KIND_PIXEL;
          pass_vert <= 1'b0;
          li        <= '0;
          line_base <= '0;
        end
      end
      S_RD_WAIT: res_pix <= frame_q;
      S_LINE_START: begin
        head <= line_base;
        tail <= line_base;
        cnt  <= '0;
        sum  <= '0;
        k    <= DIM_W'(r_eff);
      end
      S_PRIME_RD: begin
        // Remember where the first filtered pixel of this line lands
        if (cnt == WIN_W'(r_eff)) begin
          wb <= head;
        end
        head <= head + stride;
        cnt  <= cnt + 1'b1;
      end
      S_PRIME_ACC: sum <= sum + SUM_W'(frame_q);
      S_DIV_WAIT: begin
        if (div_done) begin
          k <= more ? k + 1'b1 : DIM_W'(r_eff);
        end
      end
      S_SLIDE_OLD: tail <= tail + stride;
      S_SLIDE_SUB: begin
        sum  <= sum - SUM_W'(frame_q);
        head <= head + stride;
      end
      S_SLIDE_ADD: sum <= sum + SUM_W'(frame_q);
      S_COPY_WR: begin
        wb <= wb + stride;
        if (more) begin
          k <= k + 1'b1;
        end
      end
      S_LINE_NEXT: begin
        if (more_lines) begin
          li        <= li + 1'b1;
          line_base <= line_base + line_step;
        end else begin
          // Rows done: restart at column zero
          pass_vert <= 1'b1;
          li        <= '0;
          line_base <= '0;
        end
      end
      default: ;
    endcase
  end

  // Frame memory, single port
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_addr] <= frame_wdata;
    end
    frame_q <= frame_mem[frame_addr];
  end

  // Line scratch
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[k[SCR_AW-1:0]] <= div_quot;
    end
    scr_q <= scr_mem[k[SCR_AW-1:0]];
  end

  sbb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (win),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      result_kind <= res_kind;
      pixel_out   <= res_pix;
    end
  end

  `SBB_ASSERT_IMP(a_we_phase, frame_we, (state == S_IDLE) || (state == S_COPY_WR),
                  "frame written outside load or copy-back")
  `SBB_ASSERT_NXT(a_run_ptr, in_fire && (opcode == OP_RUN), ptr == '0,
                  "run did not reset the raster pointer")
  `SBB_ASSERT_IMP(a_sum_bound, (state == S_DIV_GO) || (state == S_DIV_WAIT),
                  sum <= SUM_W'(win) * SUM_W'(PIX_MAX), "window sum out of range")

endmodule

// ===== tb/tb_separable_box_blur_gray.sv =====
module tb_separable_box_blur_gray;
  import sbb_pkg::*;

  localparam logic [OP_W-1:0]      OP_NOP       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
  localparam int unsigned          QUIET_CYCLES = 40;
  localparam int unsigned          CYCLE_LIMIT  = 4_000_000;
  localparam logic [PIX_W-1:0]     EDGE_PIXELS [12] = '{
    8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'hFF, 8'h10
  };

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [PIX_W-1:0] pixel;
    bit               drain_first;
  } blur_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIX_W-1:0]  pixel;
  } blur_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      opcode = '0;
  logic [PIX_W-1:0]     pixel_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    result_kind;
  logic [PIX_W-1:0]     pixel_out;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  blur_cmd_t    pending_ops [$];
  blur_result_t due_results [$];
  blur_result_t got_want;

  // shadow of the block: frame, line buffer, pointer, registers
  logic [PIX_W-1:0] frame_shadow [STORE_DEPTH];
  logic [PIX_W-1:0] line_buf [SCRATCH_DEPTH];
  int unsigned      raster_ptr = 0;
  logic [DIM_W-1:0] width_reg  = WIDTH_RESET;
  logic [DIM_W-1:0] height_reg = HEIGHT_RESET;
  logic [RAD_W-1:0] radius_reg = RADIUS_RESET;

  int unsigned filled_len = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  separable_box_blur_gray uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_kind(result_kind),
    .pixel_out  (pixel_out),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_extent(input logic [DIM_W-1:0] v,
                                               input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // one running-sum pass over len pixels starting at base, stride apart
  function automatic void box_filter_line(input int unsigned base, stride, len, rad);
    int unsigned span;
    int unsigned acc;
    int unsigned k;
    span = 2 * rad + 1;
    acc = 0;
    for (k = 0; k < span; k++) acc += frame_shadow[base + k * stride];
    line_buf[rad] = PIX_W'(acc / span);
    for (k = rad + 1; k + rad < len; k++) begin
      acc = acc - frame_shadow[base + (k - rad - 1) * stride]
                + frame_shadow[base + (k + rad) * stride];
      line_buf[k] = PIX_W'(acc / span);
    end
    for (k = rad; k + rad < len; k++) frame_shadow[base + k * stride] = line_buf[k];
  endfunction

  function automatic void apply_blur_op(input logic [OP_W-1:0] op,
                                        input logic [PIX_W-1:0] pix);
    int unsigned  cur_w;
    int unsigned  cur_h;
    int unsigned  rad;
    int unsigned  total;
    int unsigned  k;
    blur_result_t res;
    cur_w = clamp_extent(width_reg, MAX_WIDTH);
    cur_h = clamp_extent(height_reg, MAX_HEIGHT);
    rad   = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    total = cur_w * cur_h;
    case (op) inside
      OP_LOAD, OP_READ: begin
        if (raster_ptr >= total) raster_ptr = 0;
        if (op == OP_LOAD) begin
          frame_shadow[raster_ptr] = pix;
        end else begin
          res.kind  = KIND_PIXEL;
          res.pixel = frame_shadow[raster_ptr];
          due_results.push_back(res);
        end
        raster_ptr++;
        if (raster_ptr >= total) raster_ptr = 0;
      end
      OP_RUN: begin
        raster_ptr = 0;
        res.pixel  = '0;
        if (2 * rad + 1 > cur_w || 2 * rad + 1 > cur_h) begin
          res.kind = KIND_REFUSED;
        end else begin
          for (k = 0; k < cur_h; k++) box_filter_line(k * cur_w, 1, cur_w, rad);
          for (k = 0; k < cur_w; k++) box_filter_line(k, cur_w, cur_h, rad);
          res.kind = KIND_DONE;
        end
        due_results.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return PIX_W'(PIX_MAX);
      default: return PIX_W'($urandom_range(PIX_MAX));
    endcase
  endfunction

  function automatic void queue_op(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix,
                                   input bit hold);
    pending_ops.push_back('{op: op, pixel: pix, drain_first: hold});
  endfunction

  task automatic wait_quiet();
    while (pending_ops.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg  = data;
      REG_HEIGHT: height_reg = data;
      REG_RADIUS: radius_reg = data[RAD_W-1:0];
      default: begin
      end
    endcase
  endtask

  // new frame geometry, fill if the written area is too short, then a random mix
  // with a blur forced in the middle
  task automatic blur_phase(input int unsigned w_reg, h_reg, r_reg, n_ops, run_pct);
    logic [CFG_DAT_W-1:0] rad_word;
    logic [OP_W-1:0]      op;
    int unsigned          total;
    int unsigned          sel;
    int unsigned          i;
    wait_quiet();
    rad_word = CFG_DAT_W'($urandom);
    rad_word[RAD_W-1:0] = RAD_W'(r_reg);
    write_reg(REG_WIDTH, CFG_DAT_W'(w_reg));
    write_reg(REG_HEIGHT, CFG_DAT_W'(h_reg));
    write_reg(REG_RADIUS, rad_word);
    write_reg(REG_SPARE, CFG_DAT_W'($urandom));
    total = clamp_extent(DIM_W'(w_reg), MAX_WIDTH) * clamp_extent(DIM_W'(h_reg), MAX_HEIGHT);
    if (filled_len < total) begin
      for (i = 0; i < total; i++) queue_op(OP_LOAD, pick_pixel(), 1'b0);
      filled_len = total;
    end
    for (i = 0; i < n_ops; i++) begin
      if (i == n_ops / 2) queue_op(OP_RUN, pick_pixel(), 1'b0);
      sel = $urandom_range(99);
      if (sel < run_pct) op = OP_RUN;
      else if (sel < run_pct + 6) op = OP_NOP;
      else if ($urandom_range(1) == 1) op = OP_LOAD;
      else op = OP_READ;
      queue_op(op, pick_pixel(), $urandom_range(49) == 0);
    end
  endtask

  // sender: hold the item until taken, then present the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_blur_op(pending_ops[0].op, pending_ops[0].pixel);
        void'(pending_ops.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 &&
            !(pending_ops[0].drain_first && due_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          opcode   <= pending_ops[0].op;
          pixel_in <= pending_ops[0].pixel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each taken item against the oldest awaited result
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result with nothing awaited: result_kind %0d pixel_out %0d",
                 result_kind, pixel_out);
          error_count++;
        end else begin
          got_want = due_results.pop_front();
          if (result_kind !== got_want.kind) begin
            $error("result_kind: expected %0d, actual %0d", got_want.kind, result_kind);
            error_count++;
          end
          if (pixel_out !== got_want.pixel) begin
            $error("pixel_out: expected %0d, actual %0d", got_want.pixel, pixel_out);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int i;
    send_idle_pct = 31;
    recv_idle_pct = 69;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // small 4x3 frame: edge values, unused opcode, blur, then a refused blur
    wait_quiet();
    write_reg(REG_WIDTH, 10'd4);
    write_reg(REG_HEIGHT, 10'd3);
    write_reg(REG_RADIUS, 10'd1);
    for (i = 0; i < 12; i++) begin
      queue_op(OP_LOAD, EDGE_PIXELS[i], 1'b0);
      if (i == 5) queue_op(OP_NOP, 8'hFF, 1'b0);
    end
    filled_len = 12;
    queue_op(OP_READ, 8'h00, 1'b0);
    queue_op(OP_RUN, 8'hFF, 1'b1);
    repeat (7) queue_op(OP_READ, 8'hFF, 1'b0);
    wait_quiet();
    write_reg(REG_RADIUS, 10'd2);
    queue_op(OP_RUN, 8'h00, 1'b0);
    repeat (2) queue_op(OP_READ, 8'h00, 1'b0);

    blur_phase(8, 6, 1, 30, 6);
    blur_phase(4, 4, 0, 20, 8);
    blur_phase(0, 1, 0, 12, 10);
    blur_phase(7, 5, 2, 30, 6);

    send_idle_pct = 69;
    recv_idle_pct = 31;
    blur_phase(1023, 1, 0, 30, 3);
    blur_phase(6, 20, 3, 20, 5);
    blur_phase(1, 1023, 0, 20, 3);
    blur_phase(9, 7, 3, 20, 6);
    blur_phase(3, 3, 1, 10, 8);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    blur_phase(24, 20, 9, 10, 3);
    blur_phase(5, 5, 63, 8, 5);
    blur_phase(10, 8, 2, 20, 6);

    wait_quiet();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sbb_pkg.sv
rtl/sbb_div.sv
rtl/separable_box_blur_gray.sv
tb/tb_separable_box_blur_gray.sv
